// ===== sv/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue package
// Shared constants, command and status codes, and the controller command
// bundle that passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int ID_BITS_DEF   = 15;
  localparam int MAX_RESULTS   = 16;

  localparam int SEC_W   = 16;
  localparam int USEC_W  = 24;
  localparam int TAG_W   = 8;
  localparam int ARG_W   = 32;
  localparam int TID_W   = 15;
  localparam int STAT_W  = 3;
  localparam int DELAY_W = 44;

  localparam logic [DELAY_W-1:0] USEC_PER_SEC = DELAY_W'(1000000);

  // Input commands.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic calc;       // register deadline from product
    logic tick;       // advance the clock
    logic scan_clr;   // restart the scan index
    logic scan_tail;  // move the scan index to the tail
    logic scan_inc;   // step the scan index
    logic shift_up;   // move entry idx-1 to idx
    logic shift_dn;   // move entry idx+1 to idx
    logic write_new;  // write the new timer at idx
    logic cnt_inc;
    logic cnt_dec;
    logic id_adv;
  } sdtq_cmd_t;

endpackage

// ===== sv/sdtq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue datapath
// Entry stores, clock, id counter, scan index and deadline arithmetic.
// ----------------------------------------------------------------------------
module sdtq_datapath
  import sdtq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdtq_cmd_t             cmd,
  input  logic [SEC_W-1:0]      in_sec,
  input  logic [USEC_W-1:0]     in_usec,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic [ARG_W-1:0]      in_arg,
  input  logic [TID_W-1:0]      in_tid,
  output logic [CNT_W-1:0]      count,
  output logic [CNT_W-1:0]      idx,
  output logic                  delay_zero,
  output logic                  tag_zero,
  output logic                  ins_stop,
  output logic                  head_expired,
  output logic                  next_expired,
  output logic                  id_match,
  output logic [ID_BITS-1:0]    cur_id,
  output logic [TAG_W-1:0]      cur_tag,
  output logic [ARG_W-1:0]      cur_arg,
  output logic [ID_BITS-1:0]    new_id
);

  logic [TIME_BITS-1:0] dl_mem [CAPACITY];
  logic [ID_BITS-1:0]   id_mem [CAPACITY];
  logic [TAG_W-1:0]     tg_mem [CAPACITY];
  logic [ARG_W-1:0]     ar_mem [CAPACITY];

  logic [SEC_W-1:0]     sec_r;
  logic [USEC_W-1:0]    usec_r;
  logic [TAG_W-1:0]     tag_r;
  logic [ARG_W-1:0]     arg_r;
  logic [TID_W-1:0]     tid_r;
  logic [DELAY_W-1:0]   prod_r;
  logic [TIME_BITS-1:0] dl_r;
  logic [TIME_BITS-1:0] now_r;
  logic [ID_BITS-1:0]   nid_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     idx_r;

  logic [IDX_W-1:0]     ia, ib, ic;
  logic [DELAY_W-1:0]   delay;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] tmax;

  assign ia    = idx_r[IDX_W-1:0];
  assign ib    = IDX_W'(idx_r - CNT_W'(1));
  assign ic    = IDX_W'(idx_r + CNT_W'(1));
  assign tmax  = '1;
  assign delay = prod_r + DELAY_W'(usec_r);
  // Saturating deadline; a delay wider than the clock also saturates.
  assign sum   = {1'b0, now_r} + (TIME_BITS+1)'(delay);

  assign count        = cnt_r;
  assign idx          = idx_r;
  assign delay_zero   = (sec_r == '0) && (usec_r == '0);
  assign tag_zero     = (tag_r == '0);
  assign ins_stop     = (idx_r >= cnt_r) || (dl_mem[ia] > dl_r);
  assign head_expired = (cnt_r != '0) && (dl_mem[0] <= now_r);
  // The entry behind the head has expired too.
  assign next_expired = (cnt_r > CNT_W'(1)) && (dl_mem[1] <= now_r);
  assign id_match     = (idx_r < cnt_r) && (TID_W'(id_mem[ia]) == tid_r)
                        && ((ID_BITS <= TID_W) || (id_mem[ia] >> TID_W) == '0);
  assign cur_id       = id_mem[ia];
  assign cur_tag      = tg_mem[ia];
  assign cur_arg      = ar_mem[ia];
  assign new_id       = nid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      nid_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.tick && now_r != tmax) now_r <= now_r + TIME_BITS'(1);
      if (cmd.id_adv) nid_r <= (nid_r == '1) ? ID_BITS'(1) : nid_r + ID_BITS'(1);
      if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
      else if (cmd.cnt_dec) cnt_r <= cnt_r - CNT_W'(1);
      if (cmd.scan_clr) idx_r <= '0;
      else if (cmd.scan_tail) idx_r <= cnt_r;
      else if (cmd.scan_inc) idx_r <= idx_r + CNT_W'(1);
      else if (cmd.shift_up) idx_r <= idx_r - CNT_W'(1);
    end
  end

  // Item capture and deadline arithmetic: multiply on load, then add and saturate on calc.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r  <= in_sec;
      usec_r <= in_usec;
      tag_r  <= in_tag;
      arg_r  <= in_arg;
      tid_r  <= in_tid;
      prod_r <= DELAY_W'(in_sec) * USEC_PER_SEC;
    end
    if (cmd.calc) begin
      if (sum[TIME_BITS] || ((DELAY_W > TIME_BITS) && ((delay >> TIME_BITS) != '0)))
        dl_r <= tmax;
      else
        dl_r <= sum[TIME_BITS-1:0];
    end
  end

  // Entry store: one move per cycle.
  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      dl_mem[ia] <= dl_mem[ib];
      id_mem[ia] <= id_mem[ib];
      tg_mem[ia] <= tg_mem[ib];
      ar_mem[ia] <= ar_mem[ib];
    end else if (cmd.shift_dn) begin
      dl_mem[ia] <= dl_mem[ic];
      id_mem[ia] <= id_mem[ic];
      tg_mem[ia] <= tg_mem[ic];
      ar_mem[ia] <= ar_mem[ic];
    end else if (cmd.write_new) begin
      dl_mem[ia] <= dl_r;
      id_mem[ia] <= nid_r;
      tg_mem[ia] <= tag_r;
      ar_mem[ia] <= arg_r;
    end
  end

endmodule

// ===== sv/sdtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue controller
// Sequences add, remove and tick over the datapath and drives the result
// register.
// ----------------------------------------------------------------------------
module sdtq_ctrl
  import sdtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [TID_W-1:0]   in_tid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_data,
  output logic               out_last,
  output sdtq_cmd_t          cmd,
  input  logic [CNT_W-1:0]   count,
  input  logic [CNT_W-1:0]   idx,
  input  logic               delay_zero,
  input  logic               tag_zero,
  input  logic               ins_stop,
  input  logic               head_expired,
  input  logic               next_expired,
  input  logic               id_match,
  input  logic [ID_BITS-1:0] cur_id,
  input  logic [TAG_W-1:0]   cur_tag,
  input  logic [ARG_W-1:0]   cur_arg,
  input  logic [ID_BITS-1:0] new_id
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD0 = 4'd1;
  localparam logic [3:0] S_ADD1 = 4'd2;
  localparam logic [3:0] S_FIND = 4'd3;
  localparam logic [3:0] S_SHUP = 4'd4;
  localparam logic [3:0] S_RSCH = 4'd5;
  localparam logic [3:0] S_RSHD = 4'd6;
  localparam logic [3:0] S_TCHK = 4'd7;
  localparam logic [3:0] S_TSHD = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;
  localparam logic [3:0] S_TICK = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [TID_W-1:0]  tid_r;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [4:0]        nres_r, nres_nxt;
  logic [3:0]        ret_r, ret_nxt;
  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic [TID_W-1:0]  oid_r, oid_nxt;
  logic [TAG_W-1:0]  otg_r, otg_nxt;
  logic [ARG_W-1:0]  oar_r, oar_nxt;
  logic              ol_r, ol_nxt;
  logic [TID_W-1:0]  cur_id_t, new_id_t;

  assign cap      = CNT_W'(CAPACITY);
  assign cur_id_t = TID_W'(cur_id);
  assign new_id_t = TID_W'(new_id);
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_last  = ol_r;
  assign out_data  = {6'd0, oar_r, otg_r, oid_r, st_r};

  // Next state, datapath commands and result staging.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    nres_nxt  = nres_r;
    ret_nxt   = ret_r;
    ov_nxt    = ov_r && !out_ready;
    st_nxt    = st_r;
    oid_nxt   = oid_r;
    otg_nxt   = otg_r;
    oar_nxt   = oar_r;
    ol_nxt    = ol_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          ret_nxt = 4'd0;
          case (in_cmd)
            CMD_TICK:   state_nxt = S_TICK;
            CMD_ADD:    state_nxt = S_ADD0;
            CMD_REMOVE: state_nxt = S_RSCH;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        nres_nxt = '0;
        state_nxt = S_TCHK;
      end
      S_ADD0: begin
        cmd.calc = 1'b1;
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        if (delay_zero || tag_zero || count >= cap) begin
          st_nxt = ST_REJECTED; oid_nxt = '0; otg_nxt = '0; oar_nxt = '0;
          ol_nxt = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (ins_stop) begin
          // Remember the insert point and move the index to the tail.
          pos_nxt = idx;
          cmd.scan_tail = 1'b1;
          state_nxt = S_SHUP;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHUP: begin
        // idx walks from count down to the insert point, one move per cycle.
        if (idx == pos_r) begin
          cmd.write_new = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.id_adv = 1'b1;
          st_nxt = ST_ADDED; oid_nxt = new_id_t; otg_nxt = '0; oar_nxt = '0;
          ol_nxt = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_RSCH: begin
        if (idx >= count) begin
          st_nxt = ST_NOTFOUND; oid_nxt = tid_r; otg_nxt = '0; oar_nxt = '0;
          ol_nxt = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (id_match) begin
          st_nxt = ST_REMOVED; oid_nxt = cur_id_t; otg_nxt = cur_tag; oar_nxt = cur_arg;
          ol_nxt = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_RSHD;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_RSHD: begin
        if (idx + CNT_W'(1) < count) begin
          cmd.shift_dn = 1'b1;
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt = ret_r[3] ? S_WAIT : S_IDLE;
        end
      end
      S_TCHK: begin
        if (!ov_r || out_ready) begin
          if (head_expired && nres_r < 5'(MAX_RESULTS)) begin
            // The result is the last one unless another expired entry follows
            // and the per-tick limit still allows it.
            st_nxt = ST_EXPIRED; oid_nxt = cur_id_t; otg_nxt = cur_tag; oar_nxt = cur_arg;
            ol_nxt = !(next_expired && (nres_r + 5'd1 < 5'(MAX_RESULTS)));
            ov_nxt = 1'b1;
            nres_nxt = nres_r + 5'd1;
            ret_nxt = 4'd8;
            state_nxt = S_RSHD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        cmd.scan_clr = 1'b1;
        state_nxt = S_TCHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      nres_r  <= '0;
      ret_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      nres_r  <= nres_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) tid_r <= in_tid;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    oid_r <= oid_nxt;
    otg_r <= otg_nxt;
    oar_r <= oar_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

// ===== sv/sorted_deadline_timer_queue.sv =====
// One item at a time; the next item is taken once the controller is idle and
// the result register is empty. Reset (synchronous, active low) empties the
// queue and zeroes clock and id.
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Bounded queue of one-shot timers sorted by absolute microsecond deadline.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // delay_sec, delay_usec, handler_tag, callback_arg, target_id
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // status, timer_id, fired_tag, fired_arg
  output logic         out_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sdtq_cmd_t          cmd;
  logic [CNT_W-1:0]   count, idx;
  logic               delay_zero, tag_zero, ins_stop, head_expired, next_expired;
  logic               id_match;
  logic [ID_BITS-1:0] cur_id, new_id;
  logic [TAG_W-1:0]   cur_tag;
  logic [ARG_W-1:0]   cur_arg;

  sdtq_datapath #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_sec(in_tdata[15:0]), .in_usec(in_tdata[39:16]), .in_tag(in_tdata[47:40]),
    .in_arg(in_tdata[79:48]), .in_tid(in_tdata[94:80]),
    .count, .idx, .delay_zero, .tag_zero, .ins_stop, .head_expired, .next_expired,
    .id_match, .cur_id, .cur_tag, .cur_arg, .new_id
  );

  sdtq_ctrl #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(in_tuser),
    .in_tid(in_tdata[94:80]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_last(out_tlast),
    .cmd, .count, .idx, .delay_zero, .tag_zero, .ins_stop, .head_expired,
    .next_expired, .id_match, .cur_id, .cur_tag, .cur_arg, .new_id
  );

endmodule

// ===== sv/sdtq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted deadline timer queue port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module sdtq_checker
  import sdtq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Status codes stay in range.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[STAT_W-1:0] <= ST_EXPIRED)
    else $error("bad status");

  // Non-expiry results are always the last of their item.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STAT_W-1:0] != ST_EXPIRED |-> out_tlast)
    else $error("single result without last");

  // An item is not taken while a result waits.
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during stall");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_chk (.*);
